/* hw/rtl/matrix4_inverse_cofactor_unit_defines.svh */
// ----------------------------------------------------------------------------
// matrix4 inverse cofactor unit assertion macros
// concurrent assertion helpers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef MATRIX4_INVERSE_COFACTOR_UNIT_DEFINES_SVH
`define MATRIX4_INVERSE_COFACTOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define MIC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// condition must never hold
`define MIC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define MIC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define MIC_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

/* hw/rtl/mic_pkg.sv */
// ----------------------------------------------------------------------------
// mic_pkg
// shared types and constants of the 4x4 matrix inverse unit
// ----------------------------------------------------------------------------
package mic_pkg;

    localparam int DATA_W      = 32;
    localparam int IDX_W       = 4;
    localparam int THR_W       = 31;
    localparam int PADDR_W     = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [DATA_W-1:0] ONE_Q16      = 32'h0001_0000;
    localparam logic [THR_W-1:0]  THR_RESET    = 31'd1;

    // register map, byte address bit 2 selects the register
    typedef enum logic [0:0] {
        REG_THRESHOLD = 1'b0,
        REG_TRANSPOSE = 1'b1
    } reg_idx_t;

    // one loaded element on its way to the compute side
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] value;
    } elem_tok_t;

    // one result transaction
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [IDX_W-1:0]  index;
        logic              singular;
        logic              last;
    } result_t;

    // configuration seen by the compute side
    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic             transpose;
    } cfg_t;

endpackage

/* hw/rtl/mic_fifo.sv */
// ----------------------------------------------------------------------------
// mic_fifo
// small register queue with full/empty flags
// ----------------------------------------------------------------------------
module mic_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = store[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/mic_front.sv */
// ----------------------------------------------------------------------------
// mic_front
// input side: accepts elements and tags each with its matrix position
// ----------------------------------------------------------------------------
module mic_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic signed [31:0]         element_value,
    output logic                       q_wr_en,
    output mic_pkg::elem_tok_t         q_wr_data,
    input  logic                       q_full
);
    import mic_pkg::*;

    logic [IDX_W-1:0] load_count_reg;
    logic             accept;

    assign full             = q_full;
    assign accept           = push && !q_full;
    assign q_wr_en          = accept;
    assign q_wr_data.idx    = load_count_reg;
    assign q_wr_data.value  = element_value;

    // column-major position, wraps after sixteen elements
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= '0;
        end
        else if (accept)
        begin
            load_count_reg <= load_count_reg + 1'b1;
        end
    end

endmodule

/* hw/rtl/mic_back.sv */
// ----------------------------------------------------------------------------
// mic_back
// compute side: matrix store, cofactor/determinant sequencer, divider
// ----------------------------------------------------------------------------
`include "matrix4_inverse_cofactor_unit_defines.svh"

module mic_back (
    input  logic                clk,
    input  logic                rst_n,
    input  mic_pkg::cfg_t       cfg,
    input  logic                in_empty,
    output logic                in_rd_en,
    input  mic_pkg::elem_tok_t  in_tok,
    input  logic                out_full,
    output logic                out_wr_en,
    output mic_pkg::result_t    out_res
);
    import mic_pkg::*;

    localparam int COF_W  = 97;
    localparam int ACC_W  = 130;
    localparam int DIV_W  = 162;
    localparam int Q_W    = 34;
    localparam int MUL_W  = 33;
    localparam int PROD_W = 66;
    localparam int D2_W   = 65;

    localparam logic [3:0] COF_LAST_STEP = 4'd11;
    localparam logic [3:0] DET_LAST_STEP = 4'd15;
    localparam logic [3:0] LAST_INDEX    = 4'd15;
    localparam logic [5:0] DIV_TOP       = 6'd33;
    localparam logic [1:0] SUB_ISSUE     = 2'd0;
    localparam logic [1:0] SUB_MUL       = 2'd1;
    localparam logic [1:0] SUB_ACC       = 2'd2;
    localparam logic [1:0] PART_D2_FIRST = 2'd0;
    localparam logic [1:0] PART_D2_SUB   = 2'd1;
    localparam logic [1:0] PART_LO       = 2'd2;
    localparam logic [1:0] CHUNK_NONE    = 2'd3;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_COF,
        ST_DET,
        ST_ABS,
        ST_CHECK,
        ST_DIV_START,
        ST_DIV,
        ST_ROUND,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        SH_0,
        SH_32,
        SH_64
    } shift_t;

    state_t             state_reg;
    logic [3:0]         k_reg;
    logic [3:0]         step_reg;
    logic [1:0]         sub_reg;
    logic [5:0]         it_reg;

    logic [31:0]        mem [16];
    logic [31:0]        rd_a_reg;
    logic [31:0]        rd_b_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [D2_W-1:0]   d2_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [COF_W-1:0]   cof_reg [16];
    logic               dneg_reg;
    logic [ACC_W-1:0]   dmag_reg;
    logic               sing_reg;
    logic               neg_reg;
    logic               big_reg;
    logic [DIV_W-1:0]   rem_reg;
    logic [DIV_W-1:0]   dsh_reg;
    logic [Q_W-1:0]     q_reg;

    logic [1:0]         r_idx;
    logic [1:0]         c_idx;
    logic [1:0]         m_idx;
    logic [1:0]         part;
    logic [1:0]         p_col;
    logic [1:0]         q_col;
    logic [3:0]         addr_a;
    logic [3:0]         addr_b;
    logic signed [MUL_W-1:0] op_a;
    logic signed [MUL_W-1:0] op_b;
    shift_t             shift;
    logic               acc_neg;
    logic               acc_en;
    logic signed [ACC_W-1:0] add_base;
    logic signed [ACC_W-1:0] add_shifted;
    logic signed [ACC_W-1:0] acc_next;
    logic [3:0]         cof_sel;
    logic [3:0]         div_sel;
    logic [COF_W-1:0]   cw;
    logic [COF_W-1:0]   cabs;
    logic               ge;
    logic               rup;
    logic [Q_W-1:0]     limit;
    logic [Q_W-1:0]     sat;
    logic [31:0]        quot_value;
    logic [31:0]        ident_value;
    logic               mem_we;

    // index i of {0..3} with entry ex left out
    function automatic logic [1:0] skip_idx(input logic [1:0] i, input logic [1:0] ex);
        return (i < ex) ? i : i + 2'd1;
    endfunction

    assign r_idx = k_reg[1:0];
    assign c_idx = k_reg[3:2];
    assign m_idx = step_reg[3:2];
    assign part  = step_reg[1:0];

    // minor columns left after removing column m of the 3x3
    always_comb
    begin
        unique case (m_idx)
            2'd0:    begin p_col = 2'd1; q_col = 2'd2; end
            2'd1:    begin p_col = 2'd0; q_col = 2'd2; end
            default: begin p_col = 2'd0; q_col = 2'd1; end
        endcase
    end

    // operand decode
    always_comb
    begin
        addr_a  = '0;
        addr_b  = '0;
        op_a    = {rd_a_reg[31], rd_a_reg};
        shift   = SH_0;
        acc_neg = 1'b0;
        acc_en  = 1'b0;
        if (state_reg == ST_COF)
        begin
            acc_neg = (m_idx == 2'd1) ^ r_idx[0] ^ c_idx[0];
            unique case (part)
                PART_D2_FIRST:
                begin
                    addr_a = {skip_idx(p_col, r_idx), skip_idx(2'd1, c_idx)};
                    addr_b = {skip_idx(q_col, r_idx), skip_idx(2'd2, c_idx)};
                end
                PART_D2_SUB:
                begin
                    addr_a = {skip_idx(q_col, r_idx), skip_idx(2'd1, c_idx)};
                    addr_b = {skip_idx(p_col, r_idx), skip_idx(2'd2, c_idx)};
                end
                PART_LO:
                begin
                    addr_b = {skip_idx(m_idx, r_idx), skip_idx(2'd0, c_idx)};
                    op_a   = {1'b0, d2_reg[31:0]};
                    acc_en = 1'b1;
                end
                default:
                begin
                    addr_b = {skip_idx(m_idx, r_idx), skip_idx(2'd0, c_idx)};
                    op_a   = d2_reg[64:32];
                    shift  = SH_32;
                    acc_en = 1'b1;
                end
            endcase
        end
        else if (state_reg == ST_DET)
        begin
            // element (row 0, column j) times a cofactor chunk
            addr_b = {step_reg[3:2], 2'b00};
            acc_en = (part != CHUNK_NONE);
            unique case (part)
                2'd0:    op_a = {1'b0, cw[31:0]};
                2'd1:    begin op_a = {1'b0, cw[63:32]}; shift = SH_32; end
                default: begin op_a = cw[96:64]; shift = SH_64; end
            endcase
        end
    end

    assign op_b     = {rd_b_reg[31], rd_b_reg};
    assign add_base = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb
    begin
        unique case (shift)
            SH_0:    add_shifted = add_base;
            SH_32:   add_shifted = {add_base[ACC_W-33:0], 32'b0};
            default: add_shifted = {add_base[ACC_W-65:0], 64'b0};
        endcase
    end

    assign acc_next = acc_neg ? acc_reg - add_shifted : acc_reg + add_shifted;

    assign div_sel  = cfg.transpose ? {k_reg[1:0], k_reg[3:2]} : k_reg;
    assign cof_sel  = (state_reg == ST_DET) ? {2'b00, step_reg[3:2]} : div_sel;
    assign cw       = cof_reg[cof_sel];
    assign cabs     = cw[COF_W-1] ? COF_W'(~cw + 1'b1) : cw;

    assign ge       = (rem_reg >= dsh_reg);
    assign rup      = ({rem_reg[DIV_W-2:0], 1'b0} >= {32'b0, dmag_reg});
    assign limit    = neg_reg ? 34'h0_8000_0000 : 34'h0_7FFF_FFFF;
    assign sat      = (big_reg || (q_reg > limit)) ? limit : q_reg;
    assign quot_value  = neg_reg ? 32'(~sat[31:0] + 1'b1) : sat[31:0];
    assign ident_value = (k_reg[1:0] == k_reg[3:2]) ? ONE_Q16 : '0;

    assign in_rd_en  = (state_reg == ST_LOAD) && !in_empty;
    assign mem_we    = in_rd_en;
    assign out_wr_en = (state_reg == ST_EMIT) && !out_full;

    assign out_res.value    = sing_reg ? ident_value : quot_value;
    assign out_res.index    = k_reg;
    assign out_res.singular = sing_reg;
    assign out_res.last     = (k_reg == LAST_INDEX);

    // matrix store, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[in_tok.idx] <= in_tok.value;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_LOAD) && in_rd_en && (in_tok.idx == LAST_INDEX))
        begin
            acc_reg <= '0;
        end
        if (((state_reg == ST_COF) || (state_reg == ST_DET)) && (sub_reg == SUB_MUL))
        begin
            prod_reg <= op_a * op_b;
        end
        if ((state_reg == ST_COF) && (sub_reg == SUB_ACC))
        begin
            if (part == PART_D2_FIRST)
            begin
                d2_reg <= prod_reg[D2_W-1:0];
            end
            else if (part == PART_D2_SUB)
            begin
                d2_reg <= d2_reg - $signed(prod_reg[D2_W-1:0]);
            end
            else if (step_reg == COF_LAST_STEP)
            begin
                cof_reg[k_reg] <= acc_next[COF_W-1:0];
                acc_reg        <= '0;
            end
            else
            begin
                acc_reg <= acc_next;
            end
        end
        if ((state_reg == ST_DET) && (sub_reg == SUB_ACC) && acc_en)
        begin
            acc_reg <= acc_next;
        end
        if (state_reg == ST_ABS)
        begin
            dneg_reg <= acc_reg[ACC_W-1];
            dmag_reg <= acc_reg[ACC_W-1] ? ACC_W'(~acc_reg + 1'b1) : acc_reg;
        end
        if (state_reg == ST_DIV_START)
        begin
            rem_reg <= {33'b0, cabs, 32'b0};
            dsh_reg <= {dmag_reg[ACC_W-2:0], 33'b0};
            neg_reg <= cw[COF_W-1] ^ dneg_reg;
            big_reg <= 1'b0;
            q_reg   <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            if (it_reg == DIV_TOP)
            begin
                big_reg <= ge;
            end
            else
            begin
                if (ge)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                q_reg <= {q_reg[Q_W-2:0], ge};
            end
            dsh_reg <= {1'b0, dsh_reg[DIV_W-1:1]};
        end
        if (state_reg == ST_ROUND)
        begin
            q_reg <= q_reg + Q_W'(rup);
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            k_reg     <= '0;
            step_reg  <= '0;
            sub_reg   <= SUB_ISSUE;
            it_reg    <= '0;
            sing_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (in_rd_en && (in_tok.idx == LAST_INDEX))
                    begin
                        state_reg <= ST_COF;
                        k_reg     <= '0;
                        step_reg  <= '0;
                        sub_reg   <= SUB_ISSUE;
                    end
                end
                ST_COF:
                begin
                    if (sub_reg == SUB_ACC)
                    begin
                        sub_reg <= SUB_ISSUE;
                        if (step_reg == COF_LAST_STEP)
                        begin
                            step_reg <= '0;
                            k_reg    <= k_reg + 1'b1;
                            if (k_reg == LAST_INDEX)
                            begin
                                state_reg <= ST_DET;
                            end
                        end
                        else
                        begin
                            step_reg <= step_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        sub_reg <= sub_reg + 1'b1;
                    end
                end
                ST_DET:
                begin
                    if (sub_reg == SUB_ACC)
                    begin
                        sub_reg  <= SUB_ISSUE;
                        step_reg <= step_reg + 1'b1;
                        if (step_reg == DET_LAST_STEP)
                        begin
                            state_reg <= ST_ABS;
                        end
                    end
                    else
                    begin
                        sub_reg <= sub_reg + 1'b1;
                    end
                end
                ST_ABS:
                begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    sing_reg  <= (dmag_reg == '0) ||
                                 (dmag_reg < {51'b0, cfg.threshold, 48'b0});
                    k_reg     <= '0;
                    state_reg <= ST_DIV_START;
                end
                ST_DIV_START:
                begin
                    it_reg    <= DIV_TOP;
                    state_reg <= sing_reg ? ST_EMIT : ST_DIV;
                end
                ST_DIV:
                begin
                    it_reg <= it_reg - 1'b1;
                    if (it_reg == '0)
                    begin
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_wr_en)
                    begin
                        k_reg <= k_reg + 1'b1;
                        state_reg <= (k_reg == LAST_INDEX) ? ST_LOAD : ST_DIV_START;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    `MIC_ASSERT_NEVER(a_push_into_full, clk, rst_n, out_wr_en && out_full, "result transaction pushed into a full queue")
    `MIC_ASSERT_IMPLY(a_singular_identity, clk, rst_n, out_wr_en && sing_reg, out_res.value == ident_value, "singular result is not the identity")
    `MIC_ASSERT_IMPLY(a_remainder_bound, clk, rst_n, (state_reg == ST_ROUND) && !big_reg, rem_reg < {32'b0, dmag_reg}, "divider remainder not below divisor")

endmodule

/* hw/rtl/matrix4_inverse_cofactor_unit.sv */
// ----------------------------------------------------------------------------
// matrix4_inverse_cofactor_unit
// 4x4 signed Q16.16 matrix inverse by adjugate over determinant
// ----------------------------------------------------------------------------
// Sixteen elements are pushed in column-major order; after the sixteenth the
// unit emits sixteen result transactions (column-major, with index, singular
// flag and last marker). Each element is tagged by the input side and sits in
// a short queue until the compute side loads it, so the input keeps taking
// elements, up to the queue depth, while the previous matrix is still being
// worked on. One shared 33x33 multiplier serves every partial product in
// three steps (issue, multiply, accumulate), first for the sixteen
// cofactors and then for the determinant; a restoring divider then yields
// one quotient bit a cycle for each result. A singular matrix skips the divider.
// ----------------------------------------------------------------------------
module matrix4_inverse_cofactor_unit #(
    parameter int IN_QUEUE_DEPTH  = mic_pkg::QUEUE_DEPTH,
    parameter int OUT_QUEUE_DEPTH = mic_pkg::QUEUE_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // element input queue
    input  logic                        push,
    output logic                        full,
    input  logic signed [31:0]          element_value,
    // result queue
    input  logic                        pop,
    output logic                        empty,
    output logic signed [31:0]          result_value,
    output logic [3:0]                  element_index,
    output logic                        singular,
    output logic                        last_element,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mic_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import mic_pkg::*;

    logic [THR_W-1:0] threshold_reg;
    logic             transpose_reg;
    logic             cfg_wr;
    reg_idx_t         reg_sel;
    cfg_t             cfg;

    elem_tok_t        fe_wr_data;
    logic             fe_wr_en;
    logic             in_q_full;
    elem_tok_t        in_q_data;
    logic             in_q_empty;
    logic             in_q_rd;

    result_t          be_res;
    logic             be_wr_en;
    logic             out_q_full;
    result_t          out_q_data;

    // configuration registers, written at the access phase
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = reg_idx_t'(paddr[2]);

    always_comb
    begin
        unique case (reg_sel)
            REG_THRESHOLD: prdata = {1'b0, threshold_reg};
            default:       prdata = {31'b0, transpose_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THR_RESET;
            transpose_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_THRESHOLD: threshold_reg <= pwdata[THR_W-1:0];
                default:       transpose_reg <= pwdata[0];
            endcase
        end
    end

    assign cfg.threshold = threshold_reg;
    assign cfg.transpose = transpose_reg;

    // input side: tags each element with its position
    mic_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .element_value (element_value),
        .q_wr_en       (fe_wr_en),
        .q_wr_data     (fe_wr_data),
        .q_full        (in_q_full)
    );

    // decoupling queue between input side and compute side
    mic_fifo #(
        .WIDTH ($bits(elem_tok_t)),
        .DEPTH (IN_QUEUE_DEPTH)
    ) u_in_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fe_wr_en),
        .wr_data (fe_wr_data),
        .full    (in_q_full),
        .rd_en   (in_q_rd),
        .rd_data (in_q_data),
        .empty   (in_q_empty)
    );

    // compute side: store, cofactors, determinant, divide
    mic_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_empty  (in_q_empty),
        .in_rd_en  (in_q_rd),
        .in_tok    (in_q_data),
        .out_full  (out_q_full),
        .out_wr_en (be_wr_en),
        .out_res   (be_res)
    );

    // result queue, holds finished transactions until popped
    mic_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_QUEUE_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (be_wr_en),
        .wr_data (be_res),
        .full    (out_q_full),
        .rd_en   (pop),
        .rd_data (out_q_data),
        .empty   (empty)
    );

    assign result_value  = out_q_data.value;
    assign element_index = out_q_data.index;
    assign singular      = out_q_data.singular;
    assign last_element  = out_q_data.last;

endmodule

/* verif/tb_matrix4_inverse_cofactor_unit.sv */
// ----------------------------------------------------------------------------
// tb_matrix4_inverse_cofactor_unit
// self-checking testbench of the 4x4 Q16.16 matrix inverse unit
// ----------------------------------------------------------------------------
// Whole matrices are pushed as sixteen element transactions. A local predictor
// keeps its own copy of the element store and of the registers, and on every
// sixteenth element works out the exact adjugate, determinant and rounded,
// saturated quotients. A checker compares each popped result with the oldest
// prediction. Registers are rewritten between phases while the unit is idle,
// and the sender and receiver idle at random in several phases.
// ----------------------------------------------------------------------------
module tb_matrix4_inverse_cofactor_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import mic_pkg::*;

    // wide enough for the 4x4 determinant and the shifted cofactor
    typedef logic signed [191:0]   wide_s_t;
    typedef logic [191:0]          wide_u_t;

    typedef struct {
        logic [31:0] value;
        logic [3:0]  index;
        logic        singular;
        logic        last;
    } inverse_elem_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    logic signed [31:0]  element_value = '0;
    logic                pop = 1'b0;
    logic                empty;
    logic signed [31:0]  result_value;
    logic [3:0]          element_index;
    logic                singular;
    logic                last_element;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    // predictor state
    logic [31:0]         loaded_elems [16];
    int unsigned         load_cnt = 0;
    logic [30:0]         thr_reg = 31'd1;
    logic                transpose_reg = 1'b0;

    inverse_elem_t       pending_inverse [$];
    int unsigned         err_cnt = 0;
    int unsigned         send_idle_pct = 0;
    int unsigned         stall_pct = 0;

    matrix4_inverse_cofactor_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .element_value (element_value),
        .pop           (pop),
        .empty         (empty),
        .result_value  (result_value),
        .element_index (element_index),
        .singular      (singular),
        .last_element  (last_element),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 clk = ~clk;

    // element at row r, column c of the loaded matrix, sign extended
    function automatic wide_s_t elem_at(int r, int c);
        wide_s_t v;
        v = $signed(loaded_elems[c * 4 + r]);
        return v;
    endfunction

    // adjugate entry (r,c): signed minor without row c and column r
    function automatic wide_s_t adjugate_entry(int r, int c);
        int      rows [3];
        int      cols [3];
        int      n;
        wide_s_t x [3][3];
        wide_s_t t;
        n = 0;
        for (int i = 0; i < 4; i++)
            if (i != c)
            begin
                rows[n] = i;
                n++;
            end
        n = 0;
        for (int i = 0; i < 4; i++)
            if (i != r)
            begin
                cols[n] = i;
                n++;
            end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                x[i][j] = elem_at(rows[i], cols[j]);
        t = x[0][0] * (x[1][1] * x[2][2] - x[1][2] * x[2][1])
          - x[0][1] * (x[1][0] * x[2][2] - x[1][2] * x[2][0])
          + x[0][2] * (x[1][0] * x[2][1] - x[1][1] * x[2][0]);
        return ((r + c) % 2 == 1) ? -t : t;
    endfunction

    // round(cof * 2^32 / det), ties away from zero, saturated to 32 bits
    function automatic logic [31:0] scaled_quotient(wide_s_t cof, wide_s_t det);
        wide_s_t num;
        wide_u_t nmag;
        wide_u_t dmag;
        wide_u_t q;
        wide_u_t rem;
        wide_u_t lim;
        logic    neg;
        num  = cof <<< 32;
        neg  = (num < 0) != (det < 0);
        nmag = (num < 0) ? wide_u_t'(-num) : wide_u_t'(num);
        dmag = (det < 0) ? wide_u_t'(-det) : wide_u_t'(det);
        q    = nmag / dmag;
        rem  = nmag % dmag;
        if ((rem << 1) >= dmag)
            q = q + 1;
        lim = neg ? wide_u_t'(32'h8000_0000) : wide_u_t'(32'h7FFF_FFFF);
        if (q > lim)
            q = lim;
        return neg ? (32'd0 - q[31:0]) : q[31:0];
    endfunction

    // load one element; the sixteenth one queues the whole inverse
    task automatic predict_inverse(logic [31:0] v);
        wide_s_t       cof [16];
        wide_s_t       det;
        wide_s_t       dabs;
        wide_s_t       thr;
        logic          sing;
        inverse_elem_t e;
        int            r;
        int            c;
        loaded_elems[load_cnt] = v;
        load_cnt = (load_cnt + 1) % 16;
        if (load_cnt != 0)
            return;
        for (int k = 0; k < 16; k++)
            cof[k] = adjugate_entry(k % 4, k / 4);
        det = '0;
        for (int j = 0; j < 4; j++)
            det = det + cof[j] * elem_at(0, j);
        dabs = (det < 0) ? -det : det;
        thr  = wide_s_t'(thr_reg) <<< 48;
        sing = (det == 0) || (dabs < thr);
        for (int k = 0; k < 16; k++)
        begin
            r = k % 4;
            c = k / 4;
            if (sing)
                e.value = (r == c) ? ONE_Q16 : 32'd0;
            else if (transpose_reg)
                e.value = scaled_quotient(cof[r * 4 + c], det);
            else
                e.value = scaled_quotient(cof[k], det);
            e.index    = 4'(k);
            e.singular = sing;
            e.last     = (k == 15);
            pending_inverse.push_back(e);
        end
    endtask

    // receiver: random stalls at the rate of the current phase
    always @(posedge clk)
        pop <= ($urandom_range(99) >= stall_pct);

    // result checker
    always @(posedge clk)
    begin
        inverse_elem_t e;
        if (rst_n && pop && !empty)
        begin
            if (pending_inverse.size() == 0)
            begin
                $error("result_value: unexpected result transaction, actual %h",
                       result_value);
                err_cnt++;
            end
            else
            begin
                e = pending_inverse.pop_front();
                if (result_value !== e.value)
                begin
                    $error("result_value: expected %h, actual %h", e.value, result_value);
                    err_cnt++;
                end
                if (element_index !== e.index)
                begin
                    $error("element_index: expected %0d, actual %0d", e.index, element_index);
                    err_cnt++;
                end
                if (singular !== e.singular)
                begin
                    $error("singular: expected %0b, actual %0b", e.singular, singular);
                    err_cnt++;
                end
                if (last_element !== e.last)
                begin
                    $error("last_element: expected %0b, actual %0b", e.last, last_element);
                    err_cnt++;
                end
            end
        end
    end

    // push one element transaction, at times with a random gap in front of it
    task automatic send_element(logic [31:0] v);
        int unsigned gap;
        if ($urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 6);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push          <= 1'b1;
        element_value <= v;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_inverse(v);
    endtask

    // wait until every predicted result has been popped
    task automatic drain_results();
        push <= 1'b0;
        while (pending_inverse.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // apb write, setup then access; only called while the unit is idle
    task automatic write_reg(reg_idx_t idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << 2;
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_THRESHOLD)
            thr_reg = v[30:0];
        else
            transpose_reg = v[0];
    endtask

    // random element of a chosen flavor
    function automatic logic [31:0] rand_elem(int unsigned kind);
        logic [31:0] pick [4];
        pick[0] = 32'h7FFF_FFFF;
        pick[1] = 32'h8000_0000;
        pick[2] = 32'h0000_0000;
        pick[3] = 32'hFFFF_FFFF;
        case (kind)
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
            default: return pick[$urandom_range(0, 3)];
        endcase
    endfunction

    // one matrix with random content; some flavors are near or fully singular
    task automatic send_random_matrix();
        logic [31:0]  m [16];
        int unsigned  flavor;
        flavor = $urandom_range(0, 9);
        for (int k = 0; k < 16; k++)
            m[k] = rand_elem(flavor < 3 ? 0 : (flavor < 8 ? 1 : 2));
        if (flavor == 7)
            for (int r = 0; r < 4; r++)
                m[12 + r] = m[r];                  // two equal columns
        if (flavor == 6)
            for (int k = 0; k < 16; k++)
                m[k] = (k % 5 == 0) ? m[k] : {{12{m[k][31]}}, m[k][31:12]};
        for (int k = 0; k < 16; k++)
            send_element(m[k]);
    endtask

    // extremes, a scaled identity and a zero matrix at reset settings
    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        for (int k = 0; k < 16; k++)
            send_element((k % 5 == 0) ? 32'h0002_0000 : 32'd0);   // 2.0 * identity
        for (int k = 0; k < 16; k++)
            send_element((k % 5 == 0) ? 32'h7FFF_FFFF
                                      : ((k % 2 == 1) ? 32'h8000_0000 : 32'h0000_0001));
        for (int k = 0; k < 16; k++)
            send_element(32'd0);                                  // zero determinant
        drain_results();
    endtask

    // transposed output, zero threshold still flags a zero determinant
    task automatic test_transpose();
        write_reg(REG_TRANSPOSE, 32'h0000_0001);
        write_reg(REG_THRESHOLD, 32'h0000_0000);
        for (int k = 0; k < 16; k++)
            send_element(32'd0);
        send_random_matrix();
        drain_results();
    endtask

    // all-ones write masks to the largest threshold; sender idles
    task automatic test_max_threshold();
        send_idle_pct = 57;
        write_reg(REG_THRESHOLD, 32'hFFFF_FFFF);
        write_reg(REG_TRANSPOSE, 32'h0000_0000);
        send_random_matrix();
        drain_results();
    endtask

    // random settings and contents under stalls, with one full pause
    task automatic test_random();
        send_idle_pct = 0;
        stall_pct     = 57;
        write_reg(REG_THRESHOLD, 32'h0000_0001);
        write_reg(REG_TRANSPOSE, $urandom_range(0, 1));
        for (int i = 0; i < 2; i++)
            send_random_matrix();
        // sender holds off until the unit has delivered everything
        push <= 1'b0;
        while (pending_inverse.size() != 0)
            @(posedge clk);
        send_random_matrix();
        drain_results();
        send_idle_pct = 34;
        stall_pct     = 34;
        write_reg(REG_THRESHOLD, $urandom_range(0, 4));
        write_reg(REG_TRANSPOSE, $urandom_range(0, 1));
        for (int i = 0; i < 2; i++)
            send_random_matrix();
        drain_results();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_transpose();
        test_max_threshold();
        test_random();
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // run limit far above the slowest correct run
    initial
    begin
        #2ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/mic_pkg.sv
hw/rtl/mic_fifo.sv
hw/rtl/mic_front.sv
hw/rtl/mic_back.sv
hw/rtl/matrix4_inverse_cofactor_unit.sv
verif/tb_matrix4_inverse_cofactor_unit.sv
